// ===== hw/rtl/csrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csrs_pkg;

  localparam int NODE_COUNT_DEF = 1024;
  localparam int EDGE_COUNT_DEF = 4096;
  localparam int TYPE_BITS_DEF  = 16;

  localparam int TARGET_BITS = 10;
  localparam int INDEX_BITS  = 12;
  localparam int OFFSET_BITS = 13;
  localparam int POS_BITS    = 12;
  localparam int ETYPE_BITS  = 16;
  localparam int NODE_BITS   = 10;

  localparam int INDEX_SPAN = 1 << INDEX_BITS;

  localparam logic [1:0] REQ_OFFSET = 2'd0;
  localparam logic [1:0] REQ_EDGE   = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [INDEX_BITS-1:0]  write_index;
    logic [OFFSET_BITS-1:0] offset_value;
    logic [ETYPE_BITS-1:0]  edge_type;
    logic [TARGET_BITS-1:0] edge_target;
    logic [NODE_BITS-1:0]   query_node;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [POS_BITS-1:0] edge_position;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csr_typed_edge_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Typed edge search over a compressed-sparse-row graph held in two on-chip
// memories: a node offset table and an edge word table ({type, target}; the
// user must keep each node's words sorted ascending, which the block does not
// enforce). Every request word returns one response word. Offset and edge
// writes go straight from acceptance to the done state. A query reads the
// node's two offsets from the offset memory (one read per cycle), then runs
// a lower-bound binary search with one edge memory read per cycle; one more
// edge read is added when the final probe did not land on the answer. Each
// memory has a single read port. One request is in work at a time; a new
// request is taken while the previous response still waits in the output
// register.
module csr_typed_edge_search #(
  parameter int NODE_COUNT = csrs_pkg::NODE_COUNT_DEF,
  parameter int EDGE_COUNT = csrs_pkg::EDGE_COUNT_DEF,
  parameter int TYPE_BITS  = csrs_pkg::TYPE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire csrs_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output csrs_pkg::rsp_t      rsp
);

  localparam int OFF_DEPTH =
    (NODE_COUNT + 1 < csrs_pkg::INDEX_SPAN) ? NODE_COUNT + 1 : csrs_pkg::INDEX_SPAN;
  localparam int EDGE_DEPTH =
    (EDGE_COUNT < csrs_pkg::INDEX_SPAN) ? EDGE_COUNT : csrs_pkg::INDEX_SPAN;
  localparam int OAW = $clog2(OFF_DEPTH);
  localparam int EAW = $clog2(EDGE_DEPTH);
  localparam int WW  = TYPE_BITS + csrs_pkg::TARGET_BITS;

  logic                            off_we, off_re;
  logic [OAW-1:0]                  off_waddr, off_raddr;
  logic [csrs_pkg::OFFSET_BITS-1:0] off_wdata, off_rdata;
  logic                            edge_we, edge_re;
  logic [EAW-1:0]                  edge_waddr, edge_raddr;
  logic [WW-1:0]                   edge_wdata, edge_rdata;
  logic                            done, take;
  csrs_pkg::rsp_t                  res;

  assign take = done && (!rsp_valid || rsp_ready);

  csrs_ram #(
    .DEPTH (OFF_DEPTH),
    .WIDTH (csrs_pkg::OFFSET_BITS)
  ) u_off_ram (
    .clk   (clk),
    .we    (off_we),
    .waddr (off_waddr),
    .wdata (off_wdata),
    .re    (off_re),
    .raddr (off_raddr),
    .rdata (off_rdata)
  );

  csrs_ram #(
    .DEPTH (EDGE_DEPTH),
    .WIDTH (WW)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .re    (edge_re),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  csrs_ctrl #(
    .NODE_COUNT (NODE_COUNT),
    .EDGE_COUNT (EDGE_COUNT),
    .TYPE_BITS  (TYPE_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .off_we     (off_we),
    .off_waddr  (off_waddr),
    .off_wdata  (off_wdata),
    .off_re     (off_re),
    .off_raddr  (off_raddr),
    .off_rdata  (off_rdata),
    .edge_we    (edge_we),
    .edge_waddr (edge_waddr),
    .edge_wdata (edge_wdata),
    .edge_re    (edge_re),
    .edge_raddr (edge_raddr),
    .edge_rdata (edge_rdata),
    .done       (done),
    .res        (res),
    .take       (take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/csrs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csrs_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 26
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/csrs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csrs_ctrl #(
  parameter int NODE_COUNT = csrs_pkg::NODE_COUNT_DEF,
  parameter int EDGE_COUNT = csrs_pkg::EDGE_COUNT_DEF,
  parameter int TYPE_BITS  = csrs_pkg::TYPE_BITS_DEF,
  localparam int OFF_DEPTH =
    (NODE_COUNT + 1 < csrs_pkg::INDEX_SPAN) ? NODE_COUNT + 1 : csrs_pkg::INDEX_SPAN,
  localparam int EDGE_DEPTH =
    (EDGE_COUNT < csrs_pkg::INDEX_SPAN) ? EDGE_COUNT : csrs_pkg::INDEX_SPAN,
  localparam int OAW = $clog2(OFF_DEPTH),
  localparam int EAW = $clog2(EDGE_DEPTH),
  localparam int WW  = TYPE_BITS + csrs_pkg::TARGET_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire csrs_pkg::req_t       req,
  output logic                      off_we,
  output logic [OAW-1:0]            off_waddr,
  output logic [csrs_pkg::OFFSET_BITS-1:0] off_wdata,
  output logic                      off_re,
  output logic [OAW-1:0]            off_raddr,
  input  wire logic [csrs_pkg::OFFSET_BITS-1:0] off_rdata,
  output logic                      edge_we,
  output logic [EAW-1:0]            edge_waddr,
  output logic [WW-1:0]             edge_wdata,
  output logic                      edge_re,
  output logic [EAW-1:0]            edge_raddr,
  input  wire logic [WW-1:0]        edge_rdata,
  output logic                      done,
  output csrs_pkg::rsp_t            res,
  input  wire logic                 take
);

  localparam int CLOG_E = $clog2(EDGE_COUNT + 1);
  localparam int PW = (CLOG_E < csrs_pkg::OFFSET_BITS) ? CLOG_E : csrs_pkg::OFFSET_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OFF0  = 3'd1;
  localparam logic [2:0] S_OFF1  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           state, state_next;
  logic [OAW-1:0]       node, node_next;
  logic [TYPE_BITS-1:0] etype, etype_next;
  logic [PW-1:0]        lo, lo_next;
  logic [PW-1:0]        hi, hi_next;
  logic [PW-1:0]        lim, lim_next;
  logic [PW-1:0]        mid, mid_next;
  csrs_pkg::rsp_t       res_next;

  logic                 accept;
  logic [TYPE_BITS-1:0] req_etype;
  logic [TYPE_BITS-1:0] rtype;
  logic                 less;
  logic [PW-1:0]        off_sat;
  logic [PW-1:0]        lo_c, hi_c, mid_c;

  function automatic logic [csrs_pkg::POS_BITS-1:0] to_pos(input logic [PW-1:0] p);
    logic [31:0] wide;
    wide = 32'(p);
    return wide[csrs_pkg::POS_BITS-1:0];
  endfunction

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign done      = (state == S_DONE);
  assign req_etype = TYPE_BITS'(req.edge_type);
  assign rtype     = edge_rdata[WW-1 -: TYPE_BITS];
  assign less      = (rtype < etype);
  assign off_sat   = (32'(off_rdata) > 32'(EDGE_COUNT)) ? PW'(EDGE_COUNT) : PW'(off_rdata);

  assign off_waddr  = OAW'(req.write_index);
  assign off_wdata  = req.offset_value;
  assign edge_waddr = EAW'(req.write_index);
  assign edge_wdata = {req_etype, req.edge_target};

  always_comb begin
    lo_c = lo;
    hi_c = hi;
    if (state == S_OFF1) begin
      hi_c = off_sat;
    end else if (less) begin
      lo_c = mid + PW'(1);
    end else begin
      hi_c = mid;
    end
    mid_c = lo_c + ((hi_c - lo_c) >> 1);
  end

  always_comb begin
    state_next = state;
    node_next  = node;
    etype_next = etype;
    lo_next    = lo;
    hi_next    = hi;
    lim_next   = lim;
    mid_next   = mid;
    res_next   = res;
    off_we     = 1'b0;
    off_re     = 1'b0;
    off_raddr  = node;
    edge_we    = 1'b0;
    edge_re    = 1'b0;
    edge_raddr = mid_c[EAW-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_next   = '0;
          etype_next = req_etype;
          state_next = S_DONE;
          unique case (req.req_type)
            csrs_pkg::REQ_OFFSET: begin
              off_we = (32'(req.write_index) <= 32'(NODE_COUNT));
            end
            csrs_pkg::REQ_EDGE: begin
              edge_we = (32'(req.write_index) < 32'(EDGE_COUNT));
            end
            csrs_pkg::REQ_QUERY: begin
              if (32'(req.query_node) < 32'(NODE_COUNT)) begin
                off_re     = 1'b1;
                off_raddr  = OAW'(req.query_node);
                node_next  = OAW'(32'(req.query_node) + 1);
                state_next = S_OFF0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_OFF0: begin
        lo_next    = off_sat;
        off_re     = 1'b1;
        state_next = S_OFF1;
      end
      S_OFF1: begin
        hi_next  = hi_c;
        lim_next = hi_c;
        if (lo < hi_c) begin
          edge_re    = 1'b1;
          mid_next   = mid_c;
          state_next = S_CMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CMP: begin
        lo_next = lo_c;
        hi_next = hi_c;
        if (lo_c < hi_c) begin
          edge_re  = 1'b1;
          mid_next = mid_c;
        end else if (lo_c >= lim) begin
          state_next = S_DONE;
        end else if (!less) begin
          res_next.found         = (rtype == etype);
          res_next.edge_position = (rtype == etype) ? to_pos(mid) : '0;
          state_next             = S_DONE;
        end else begin
          edge_re    = 1'b1;
          edge_raddr = lo_c[EAW-1:0];
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        res_next.found         = (rtype == etype);
        res_next.edge_position = (rtype == etype) ? to_pos(lo) : '0;
        state_next             = S_DONE;
      end
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    node  <= node_next;
    etype <= etype_next;
    lo    <= lo_next;
    hi    <= hi_next;
    lim   <= lim_next;
    mid   <= mid_next;
    res   <= res_next;
  end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int TOTAL_ITEMS  = 900;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_SEG      = 40;
  localparam int WORD_BITS    = csrs_pkg::ETYPE_BITS + csrs_pkg::TARGET_BITS;

  class edge_search_board;
    logic [csrs_pkg::OFFSET_BITS-1:0] offset_tab [0:csrs_pkg::NODE_COUNT_DEF];
    bit                     offset_set [0:csrs_pkg::NODE_COUNT_DEF];
    logic [WORD_BITS-1:0]   edge_tab [0:csrs_pkg::EDGE_COUNT_DEF-1];
    bit                     edge_set [0:csrs_pkg::EDGE_COUNT_DEF-1];
    csrs_pkg::rsp_t awaiting[$];
    int errors;
    int n_queries;
    int n_hits;
    int n_writes;
    int n_other;

    function int unsigned clamped_offset(int node);
      int unsigned v;
      v = offset_tab[node];
      return (v > csrs_pkg::EDGE_COUNT_DEF) ? csrs_pkg::EDGE_COUNT_DEF : v;
    endfunction

    function bit query_safe(int node);
      int unsigned lo;
      int unsigned hi;
      if (!offset_set[node] || !offset_set[node+1]) return 0;
      lo = clamped_offset(node);
      hi = clamped_offset(node + 1);
      for (int unsigned p = lo; p < hi; p++) begin
        if (!edge_set[p]) return 0;
      end
      return 1;
    endfunction

    function csrs_pkg::rsp_t search_first_edge(csrs_pkg::req_t r);
      csrs_pkg::rsp_t a;
      int unsigned lo;
      int unsigned hi;
      int unsigned stop;
      int unsigned mid;
      logic [WORD_BITS-1:0] key;
      a = '0;
      case (r.req_type)
        csrs_pkg::REQ_OFFSET: begin
          n_writes++;
          if (r.write_index <= csrs_pkg::NODE_COUNT_DEF) begin
            offset_tab[r.write_index] = r.offset_value;
            offset_set[r.write_index] = 1;
          end
        end
        csrs_pkg::REQ_EDGE: begin
          n_writes++;
          if (r.write_index < csrs_pkg::EDGE_COUNT_DEF) begin
            edge_tab[r.write_index] = {r.edge_type, r.edge_target};
            edge_set[r.write_index] = 1;
          end
        end
        csrs_pkg::REQ_QUERY: begin
          n_queries++;
          lo = clamped_offset(int'(r.query_node));
          stop = clamped_offset(int'(r.query_node) + 1);
          hi = stop;
          key = {r.edge_type, {csrs_pkg::TARGET_BITS{1'b0}}};
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (edge_tab[mid] < key) lo = mid + 1;
            else hi = mid;
          end
          if (lo < stop) begin
            if (edge_tab[lo][WORD_BITS-1:csrs_pkg::TARGET_BITS] == r.edge_type) begin
              a.found = 1'b1;
              a.edge_position = csrs_pkg::POS_BITS'(lo);
              n_hits++;
            end
          end
        end
        default: n_other++;
      endcase
      return a;
    endfunction

    function void note_request(csrs_pkg::req_t r);
      awaiting.push_back(search_first_edge(r));
    endfunction

    function void check_response(csrs_pkg::rsp_t got);
      csrs_pkg::rsp_t want;
      if (awaiting.size() == 0) begin
        $error("response with nothing outstanding: found=%0d edge_position=%0d",
               got.found, got.edge_position);
        errors++;
        return;
      end
      want = awaiting.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.edge_position !== want.edge_position) begin
        $error("edge_position: expected %0d, actual %0d",
               want.edge_position, got.edge_position);
        errors++;
      end
    endfunction

    function int pending_count();
      return awaiting.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  csrs_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  csrs_pkg::rsp_t rsp;

  bit hold_receiver = 0;
  bit steady = 0;
  int items_sent = 0;
  int built_nodes[$];
  edge_search_board board = new();

  csr_typed_edge_search dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_response(rsp);
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_receiver && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
        if (hold_left == 0) hold_receiver = 0;
      end else begin
        rsp_ready <= steady || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic csrs_pkg::req_t fresh_req(logic [1:0] code);
    csrs_pkg::req_t r;
    r.req_type     = code;
    r.write_index  = csrs_pkg::INDEX_BITS'($urandom);
    r.offset_value = csrs_pkg::OFFSET_BITS'($urandom);
    r.edge_type    = csrs_pkg::ETYPE_BITS'($urandom);
    r.edge_target  = csrs_pkg::TARGET_BITS'($urandom);
    r.query_node   = csrs_pkg::NODE_BITS'($urandom);
    return r;
  endfunction

  task automatic send_req(input csrs_pkg::req_t r);
    while (!steady && $urandom_range(0, 99) < 19) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.note_request(r);
    items_sent++;
  endtask

  task automatic send_offset(input int idx, input int val);
    csrs_pkg::req_t r;
    r = fresh_req(csrs_pkg::REQ_OFFSET);
    r.write_index = csrs_pkg::INDEX_BITS'(idx);
    r.offset_value = csrs_pkg::OFFSET_BITS'(val);
    send_req(r);
  endtask

  task automatic send_edge(input int idx, input logic [15:0] ty, input logic [9:0] tgt);
    csrs_pkg::req_t r;
    r = fresh_req(csrs_pkg::REQ_EDGE);
    r.write_index = csrs_pkg::INDEX_BITS'(idx);
    r.edge_type = ty;
    r.edge_target = tgt;
    send_req(r);
  endtask

  task automatic send_query(input int node, input logic [15:0] ty);
    csrs_pkg::req_t r;
    r = fresh_req(csrs_pkg::REQ_QUERY);
    r.query_node = csrs_pkg::NODE_BITS'(node);
    r.edge_type = ty;
    send_req(r);
  endtask

  task automatic wait_for_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (board.pending_count() != 0);
  endtask

  task automatic run_graph_episode();
    int nodes;
    int n0;
    int base;
    int total;
    int pos;
    int cnt;
    int node;
    int len [5];
    logic [15:0] pool [3];
    logic [15:0] ty;
    logic [25:0] seg [MAX_SEG];
    logic [25:0] tmp;
    nodes = $urandom_range(1, 4);
    n0 = $urandom_range(0, csrs_pkg::NODE_COUNT_DEF - nodes);
    total = 0;
    for (int i = 0; i < nodes; i++) begin
      len[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(7, MAX_SEG) : $urandom_range(0, 6);
      total += len[i];
    end
    base = $urandom_range(0, csrs_pkg::EDGE_COUNT_DEF - total);
    pool[0] = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
    pool[1] = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
    pool[2] = 16'($urandom);
    pos = base;
    for (int i = 0; i < nodes; i++) begin
      for (int j = 0; j < len[i]; j++) begin
        tmp = {pool[$urandom_range(0, 2)],
               ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom)};
        // insert in ascending order
        cnt = j;
        while (cnt > 0 && seg[cnt-1] > tmp) begin
          seg[cnt] = seg[cnt-1];
          cnt--;
        end
        seg[cnt] = tmp;
      end
      if (len[i] >= 2 && $urandom_range(0, 6) == 0) begin
        tmp = seg[0];
        seg[0] = seg[len[i]-1];
        seg[len[i]-1] = tmp;
      end
      for (int j = 0; j < len[i]; j++) begin
        send_edge(pos + j, seg[j][25:10], seg[j][9:0]);
      end
      pos += len[i];
    end
    pos = base;
    for (int i = 0; i <= nodes; i++) begin
      if ($urandom_range(0, 9) == 0) send_offset(n0 + i, $urandom_range(0, 8191));
      else send_offset(n0 + i, pos);
      if (i < nodes) begin
        pos += len[i];
        built_nodes.push_back(n0 + i);
      end
    end
    cnt = $urandom_range(2, 6);
    for (int k = 0; k < cnt; k++) begin
      node = n0 + $urandom_range(0, nodes - 1);
      case ($urandom_range(0, 3))
        0: ty = 16'($urandom);
        1: ty = pool[$urandom_range(0, 2)] + (($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF);
        default: ty = pool[$urandom_range(0, 2)];
      endcase
      if (board.query_safe(node)) send_query(node, ty);
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_edge($urandom_range(0, csrs_pkg::EDGE_COUNT_DEF - 1), 16'($urandom),
                   10'($urandom));
      1: send_offset($urandom_range(csrs_pkg::NODE_COUNT_DEF + 1, csrs_pkg::INDEX_SPAN - 1),
                     $urandom_range(0, 8191));
      2: send_req(fresh_req(REQ_UNUSED));
      default: send_offset($urandom_range(0, csrs_pkg::NODE_COUNT_DEF),
                           $urandom_range(0, 8191));
    endcase
  endtask

  initial begin : stimulus
    int pick;
    int node;
    bit held;
    bit paused;
    held = 0;
    paused = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_offset(0, 0);
    send_offset(1, 3);
    send_offset(2, 3);
    send_offset(3, 1);
    send_edge(0, 16'd0, 10'd0);
    send_edge(1, 16'd5, 10'd0);
    send_edge(2, 16'd5, 10'd1023);
    send_query(0, 16'd0);
    send_query(0, 16'd5);
    send_query(0, 16'd6);
    send_query(0, 16'd3);
    send_query(1, 16'd5);
    send_query(2, 16'd5);
    send_offset(1023, 4093);
    send_offset(1024, 8191);
    send_edge(4093, 16'd7, 10'd2);
    send_edge(4094, 16'hFFFF, 10'd0);
    send_edge(4095, 16'hFFFF, 10'd1023);
    send_query(1023, 16'hFFFF);
    send_query(1023, 16'd0);
    send_offset(4095, 0);
    send_offset(1025, 8191);
    send_req(fresh_req(REQ_UNUSED));

    while (items_sent < TOTAL_ITEMS) begin
      steady = (items_sent >= 600 && items_sent < 760);
      if (!held && items_sent >= 250) begin
        held = 1;
        hold_receiver = 1;
      end
      if (!paused && items_sent >= 500) begin
        paused = 1;
        wait_for_drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run_graph_episode();
      end else if (pick < 85 || built_nodes.size() == 0) begin
        send_noise();
      end else begin
        node = built_nodes[$urandom_range(0, built_nodes.size() - 1)];
        if (board.query_safe(node)) send_query(node, 16'($urandom));
      end
    end
    steady = 0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d requests: %0d table writes, %0d queries (%0d hits), %0d unknown",
             items_sent, board.n_writes, board.n_queries, board.n_hits, board.n_other);
    if (board.errors == 0 && board.pending_count() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== csr_typed_edge_search.f =====
hw/rtl/csrs_pkg.sv
hw/rtl/csrs_ram.sv
hw/rtl/csrs_ctrl.sv
hw/rtl/csr_typed_edge_search.sv
verif/tb_top.sv
